// ----- hw/rtl/sfd_pkg.sv -----
// Shared types, constants and helper functions for the stereo feedback delay.
`default_nettype none

package sfd_pkg;

    // Sample width and delay memory depth (depth must be a power of two)
    localparam int SAMPLE_BITS  = 24;
    localparam int BUFFER_DEPTH = 16384;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

    // Register field widths
    localparam int DELAY_W = 14;
    localparam int FB_W    = 16;
    localparam int GAIN_W  = 17;

    // Fixed-point arithmetic with 16 fraction bits: feedback gain Q0.16, other gains Q1.16
    localparam int Q_FRAC = 16;
    localparam logic [GAIN_W-1:0] Q_ONE = GAIN_W'(65536);

    // Internal widths
    localparam int SUM_W      = SAMPLE_BITS + 1;
    localparam int WET_PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int FB_PROD_W  = SAMPLE_BITS + FB_W + 1;
    localparam int MS_PROD_W  = SUM_W + GAIN_W + 1;
    localparam int SAT_W      = 48;

    localparam logic signed [SAT_W-1:0] SMP_MAX = (SAT_W'(1) <<< (SAMPLE_BITS - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] SMP_MIN = -SMP_MAX - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] HALF_Q  = SAT_W'(1) <<< (Q_FRAC - 1);
    localparam logic signed [SAT_W-1:0] HALF_MS = SAT_W'(1) <<< Q_FRAC;

    // Configuration port
    localparam int NUM_REGS   = 5;
    localparam int CFG_ADDR_W = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;
    localparam int APB_DATA_W = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DELAY,
        REG_FEEDBACK,
        REG_MIX,
        REG_WIDTH,
        REG_WET
    } reg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } sfd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } sfd_out_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_samples;
        logic [FB_W-1:0]    feedback_gain;
        logic [GAIN_W-1:0]  mix_level;
        logic [GAIN_W-1:0]  width;
        logic [GAIN_W-1:0]  wet_gain;
    } sfd_cfg_t;

    // Where a lane takes its delayed sample from
    typedef enum logic [1:0] {
        RD_MEM,
        RD_BYPASS,
        RD_ZERO
    } rd_src_t;

    typedef struct packed {
        logic              rd_en;
        logic              wet_en;
        logic              rnd_en;
        logic              fb_en;
        logic              wr_en;
        rd_src_t           rd_src;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
    } lane_ctrl_t;

    typedef struct packed {
        logic ms_en;
        logic wsat_en;
        logic mix_en;
        logic out_en;
    } merge_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WET,
        ST_ROUND,
        ST_FB,
        ST_WRITE,
        ST_MIX,
        ST_OUT
    } sfd_state_t;

    function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] v);
        sample_t r;
        if (v > SMP_MAX) begin
            r = SMP_MAX[SAMPLE_BITS-1:0];
        end
        else if (v < SMP_MIN) begin
            r = SMP_MIN[SAMPLE_BITS-1:0];
        end
        else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sfd_lane.sv -----
// One channel: delay memory, wet gain and feedback write-back.
`default_nettype none

module sfd_lane (
    input  wire logic               clk,
    input  wire sfd_pkg::lane_ctrl_t ctrl,
    input  wire sfd_pkg::sfd_cfg_t   cfg,
    input  wire sfd_pkg::sample_t    x,
    output sfd_pkg::sample_t         d
);
    import sfd_pkg::*;

    sample_t line_mem [BUFFER_DEPTH];

    sample_t                       rd_data_reg;
    rd_src_t                       src_reg;
    logic signed [WET_PROD_W-1:0]  wet_prod_reg;
    logic signed [WET_PROD_W-1:0]  wet_prod_next;
    sample_t                       d_reg;
    sample_t                       d_next;
    logic signed [FB_PROD_W-1:0]   fb_prod_reg;
    logic signed [FB_PROD_W-1:0]   fb_prod_next;
    sample_t                       wr_data;
    sample_t                       r_sel;
    logic signed [SAT_W-1:0]       fb_round;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= line_mem[ctrl.rd_addr];
        end
        if (ctrl.wr_en)
        begin
            line_mem[ctrl.wr_addr] <= wr_data;
        end
    end

    // delayed sample: memory, current input (zero delay), or zero for an unwritten entry
    always_comb
    begin
        unique case (src_reg)
            RD_MEM:    r_sel = rd_data_reg;
            RD_BYPASS: r_sel = x;
            RD_ZERO:   r_sel = '0;
            default:   r_sel = '0;
        endcase
    end

    assign wet_prod_next = WET_PROD_W'(r_sel) * $signed({1'b0, cfg.wet_gain});
    assign d_next        = sat_sample((SAT_W'(wet_prod_reg) + HALF_Q) >>> Q_FRAC);
    assign fb_prod_next  = FB_PROD_W'(d_reg) * $signed({1'b0, cfg.feedback_gain});
    assign fb_round      = (SAT_W'(fb_prod_reg) + HALF_Q) >>> Q_FRAC;
    // zero feedback gives a zero product, so the slot keeps the plain input
    assign wr_data       = sat_sample(SAT_W'(x) + fb_round);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            src_reg <= ctrl.rd_src;
        end
        if (ctrl.wet_en)
        begin
            wet_prod_reg <= wet_prod_next;
        end
        if (ctrl.rnd_en)
        begin
            d_reg <= d_next;
        end
        if (ctrl.fb_en)
        begin
            fb_prod_reg <= fb_prod_next;
        end
    end

    assign d = d_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sfd_merge.sv -----
// Mid/side width stage and dry/wet mix of the two lanes.
`default_nettype none

module sfd_merge (
    input  wire logic                 clk,
    input  wire sfd_pkg::merge_ctrl_t ctrl,
    input  wire sfd_pkg::sfd_cfg_t    cfg,
    input  wire sfd_pkg::sfd_in_t     dry,
    input  wire sfd_pkg::sample_t     dl,
    input  wire sfd_pkg::sample_t     dr,
    output sfd_pkg::sfd_out_t         result
);
    import sfd_pkg::*;

    logic signed [SUM_W-1:0]     s_reg;
    logic signed [SUM_W-1:0]     s_next;
    logic signed [SUM_W-1:0]     diff;
    logic signed [MS_PROD_W-1:0] ms_prod_reg;
    logic signed [MS_PROD_W-1:0] ms_prod_next;
    logic signed [SAT_W-1:0]     ms_base;
    sample_t                     wl_reg;
    sample_t                     wr_reg;
    sample_t                     wl_next;
    sample_t                     wr_next;
    logic [GAIN_W-1:0]           mix_m;
    logic signed [SUM_W-1:0]     mdiff_l;
    logic signed [SUM_W-1:0]     mdiff_r;
    logic signed [MS_PROD_W-1:0] mix_l_reg;
    logic signed [MS_PROD_W-1:0] mix_r_reg;
    logic signed [MS_PROD_W-1:0] mix_l_next;
    logic signed [MS_PROD_W-1:0] mix_r_next;
    sfd_out_t                    out_reg;
    sfd_out_t                    out_next;

    assign s_next       = SUM_W'(dl) + SUM_W'(dr);
    assign diff         = SUM_W'(dl) - SUM_W'(dr);
    assign ms_prod_next = MS_PROD_W'(diff) * $signed({1'b0, cfg.width});

    // (S*2^16 +/- D*width + 2^16) >> 17
    assign ms_base = (SAT_W'(s_reg) <<< Q_FRAC) + HALF_MS;
    assign wl_next = sat_sample((ms_base + SAT_W'(ms_prod_reg)) >>> (Q_FRAC + 1));
    assign wr_next = sat_sample((ms_base - SAT_W'(ms_prod_reg)) >>> (Q_FRAC + 1));

    // x*(1-m) + w*m rewritten as x + (w-x)*m, one multiply per channel
    assign mix_m      = (cfg.mix_level > Q_ONE) ? Q_ONE : cfg.mix_level;
    assign mdiff_l    = SUM_W'(wl_reg) - SUM_W'(dry.left_in);
    assign mdiff_r    = SUM_W'(wr_reg) - SUM_W'(dry.right_in);
    assign mix_l_next = MS_PROD_W'(mdiff_l) * $signed({1'b0, mix_m});
    assign mix_r_next = MS_PROD_W'(mdiff_r) * $signed({1'b0, mix_m});

    assign out_next.left_out  = sat_sample(((SAT_W'(dry.left_in) <<< Q_FRAC)
                                + SAT_W'(mix_l_reg) + HALF_Q) >>> Q_FRAC);
    assign out_next.right_out = sat_sample(((SAT_W'(dry.right_in) <<< Q_FRAC)
                                + SAT_W'(mix_r_reg) + HALF_Q) >>> Q_FRAC);

    always_ff @(posedge clk)
    begin
        if (ctrl.ms_en)
        begin
            s_reg       <= s_next;
            ms_prod_reg <= ms_prod_next;
        end
        if (ctrl.wsat_en)
        begin
            wl_reg <= wl_next;
            wr_reg <= wr_next;
        end
        if (ctrl.mix_en)
        begin
            mix_l_reg <= mix_l_next;
            mix_r_reg <= mix_r_next;
        end
        if (ctrl.out_en)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_feedback_delay_unit.sv -----
// Top level: sequencer, write pointer, configuration registers, two lanes and merge.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | input     | in_valid/in_ready  | in_data  (left_in, right_in)
//  out     | output    | out_valid/out_ready| out_data (left_out, right_out)
//  cfg     | input     | APB, pready tied 1 | paddr/pwdata/prdata
//
// One beat is worked on at a time, in these steps: accept, then read, wet multiply,
// round, feedback and width multiply, write-back, mix multiply, output load. The pace
// is set by the read-modify-write of each lane's single-port delay memory and a
// register after every multiply. While a result waits, one more input beat is
// taken and carried to the last step, where the sequencer holds; input then stalls
// until the waiting result leaves. Reset clears control state and loads the default
// settings; unwritten delay entries read as zero via a wrap flag, so no clearing
// pass is needed.
`default_nettype none

module stereo_feedback_delay_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire sfd_pkg::sfd_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output sfd_pkg::sfd_out_t                     out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [sfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfd_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import sfd_pkg::*;

    sfd_state_t        state_reg;
    sfd_state_t        state_next;
    sfd_cfg_t          cfg_reg;
    sfd_cfg_t          cfg_next;
    sfd_in_t           sample_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic              filled_reg;
    logic              filled_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] dly_mod;
    logic [ADDR_W-1:0] rd_addr;
    rd_src_t           rd_src;
    lane_ctrl_t        lane_ctrl;
    merge_ctrl_t       merge_ctrl;
    sample_t           dl;
    sample_t           dr;
    logic              in_beat;
    logic              slot_free;
    logic              cfg_wr;
    reg_idx_t          reg_idx;

    assign in_beat   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DELAY:    cfg_next.delay_samples = pwdata[DELAY_W-1:0];
                REG_FEEDBACK: cfg_next.feedback_gain = pwdata[FB_W-1:0];
                REG_MIX:      cfg_next.mix_level     = pwdata[GAIN_W-1:0];
                REG_WIDTH:    cfg_next.width         = pwdata[GAIN_W-1:0];
                REG_WET:      cfg_next.wet_gain      = pwdata[GAIN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DELAY:    prdata = APB_DATA_W'(cfg_reg.delay_samples);
            REG_FEEDBACK: prdata = APB_DATA_W'(cfg_reg.feedback_gain);
            REG_MIX:      prdata = APB_DATA_W'(cfg_reg.mix_level);
            REG_WIDTH:    prdata = APB_DATA_W'(cfg_reg.width);
            REG_WET:      prdata = APB_DATA_W'(cfg_reg.wet_gain);
            default:      prdata = '0;
        endcase
    end

    // ---------------- read address and source ----------------
    // delay taken modulo the depth; rd_addr wraps in ADDR_W bits
    assign dly_mod = ADDR_W'(cfg_reg.delay_samples);
    assign rd_addr = wp_reg - dly_mod;

    always_comb
    begin
        priority if (dly_mod == '0)
        begin
            rd_src = RD_BYPASS;
        end
        else if (!filled_reg && (rd_addr > wp_reg))
        begin
            rd_src = RD_ZERO;
        end
        else
        begin
            rd_src = RD_MEM;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_WET;
            ST_WET:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_FB;
            ST_FB:    state_next = ST_WRITE;
            ST_WRITE: state_next = ST_MIX;
            ST_MIX:   state_next = ST_OUT;
            ST_OUT:   if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        lane_ctrl         = '0;
        lane_ctrl.rd_src  = rd_src;
        lane_ctrl.rd_addr = rd_addr;
        lane_ctrl.wr_addr = wp_reg;
        merge_ctrl        = '0;
        in_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_READ:  lane_ctrl.rd_en = 1'b1;
            ST_WET:   lane_ctrl.wet_en = 1'b1;
            ST_ROUND: lane_ctrl.rnd_en = 1'b1;
            ST_FB:
            begin
                lane_ctrl.fb_en  = 1'b1;
                merge_ctrl.ms_en = 1'b1;
            end
            ST_WRITE:
            begin
                lane_ctrl.wr_en    = 1'b1;
                merge_ctrl.wsat_en = 1'b1;
            end
            ST_MIX:   merge_ctrl.mix_en = 1'b1;
            ST_OUT:   merge_ctrl.out_en = slot_free;
            default:  in_ready = 1'b0;
        endcase
    end

    // write pointer advances after write-back; flag marks first full wrap
    always_comb
    begin
        wp_next     = wp_reg;
        filled_next = filled_reg;
        if (lane_ctrl.wr_en)
        begin
            wp_next = wp_reg + ADDR_W'(1);
            if (wp_reg == '1)
            begin
                filled_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (merge_ctrl.out_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                   <= ST_IDLE;
            wp_reg                      <= '0;
            filled_reg                  <= 1'b0;
            out_valid_reg               <= 1'b0;
            cfg_reg.delay_samples       <= DELAY_W'(2205);
            cfg_reg.feedback_gain       <= FB_W'(13107);
            cfg_reg.mix_level           <= GAIN_W'(32768);
            cfg_reg.width               <= GAIN_W'(32768);
            cfg_reg.wet_gain            <= GAIN_W'(58196);
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sample_reg <= in_data;
        end
    end

    // ---------------- datapath ----------------
    sfd_lane u_lane_l (
        .clk  (clk),
        .ctrl (lane_ctrl),
        .cfg  (cfg_reg),
        .x    (sample_reg.left_in),
        .d    (dl)
    );

    sfd_lane u_lane_r (
        .clk  (clk),
        .ctrl (lane_ctrl),
        .cfg  (cfg_reg),
        .x    (sample_reg.right_in),
        .d    (dr)
    );

    sfd_merge u_merge (
        .clk    (clk),
        .ctrl   (merge_ctrl),
        .cfg    (cfg_reg),
        .dry    (sample_reg),
        .dl     (dl),
        .dr     (dr),
        .result (out_data)
    );

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sfd_checker.sv -----
// Port-level checks for the stereo feedback delay and their bind to the top level.
`default_nettype none

module sfd_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire sfd_pkg::sfd_in_t               in_data,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire sfd_pkg::sfd_out_t              out_data,
    input wire logic                           psel,
    input wire logic                           penable,
    input wire logic                           pwrite,
    input wire logic [sfd_pkg::CFG_ADDR_W-1:0] paddr,
    input wire logic [sfd_pkg::APB_DATA_W-1:0] pwdata,
    input wire logic [sfd_pkg::APB_DATA_W-1:0] prdata,
    input wire logic                           pready
);
    import sfd_pkg::*;

    logic in_beat;
    logic apb_access;

    assign in_beat    = in_valid && in_ready;
    assign apb_access = psel && penable && pwrite && (paddr == paddr)
                        && (pwdata == pwdata) && (prdata == prdata);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // the block works on one sample pair at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
                    ##1 !in_ready ##1 !in_ready)
        else $error("input taken while previous pair in flight");

    // a fresh result is traced back to its input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_beat, 8))
        else $error("result without matching input beat");

    // config writes complete in the access cycle
    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        apb_access |-> pready)
        else $error("APB access stalled");

    // no result beat without a pair having been taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready, 1) && (in_data == in_data))
        else $error("result rose while idle");

endmodule

bind stereo_feedback_delay_unit sfd_checker u_sfd_checker (.*);

`default_nettype wire

// ----- tb/stereo_delay_checker.sv -----
// Checker for the stereo feedback delay: tracks both delay lines and compares each output beat.
`timescale 1ns / 100ps

module stereo_delay_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire sfd_pkg::sfd_in_t                 in_data,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire sfd_pkg::sfd_out_t                out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic                             pready,
    input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [sfd_pkg::APB_DATA_W-1:0]   pwdata,
    output int                                    mismatches,
    output int                                    awaiting
);
    import sfd_pkg::*;

    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(2205);
    localparam logic [FB_W-1:0]    FB_RST    = FB_W'(13107);
    localparam logic [GAIN_W-1:0]  MIX_RST   = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0]  WIDTH_RST = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0]  WET_RST   = GAIN_W'(58196);
    localparam longint UNITY    = 65536;
    localparam longint LEVEL_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint LEVEL_LO = -LEVEL_HI - 1;

    logic [DELAY_W-1:0] dly_cfg;
    logic [FB_W-1:0]    fb_cfg;
    logic [GAIN_W-1:0]  mix_cfg;
    logic [GAIN_W-1:0]  width_cfg;
    logic [GAIN_W-1:0]  wet_cfg;

    // index 0 is the left line, 1 the right
    logic signed [SAMPLE_BITS-1:0] line_mem [2][BUFFER_DEPTH];
    logic [ADDR_W-1:0]             wr_ptr;

    sfd_out_t expected_pairs[$];
    sfd_out_t got;
    sfd_out_t want;
    int       out_beats;

    function automatic longint clamp_level(input longint v);
        if (v > LEVEL_HI)
        begin
            return LEVEL_HI;
        end
        if (v < LEVEL_LO)
        begin
            return LEVEL_LO;
        end
        return v;
    endfunction

    // floor((v + 2^(s-1)) / 2^s): round to nearest, ties up
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Write the new sample, read the tap, then fold feedback into the slot just written
    function automatic longint lane_tap(input int ch, input longint x,
                                        input logic [ADDR_W-1:0] rd);
        longint d;
        longint fb;
        longint slot;
        line_mem[ch][wr_ptr] = x[SAMPLE_BITS-1:0];
        d = clamp_level(round_shift(longint'(line_mem[ch][rd]) * longint'(wet_cfg), Q_FRAC));
        if (fb_cfg != '0)
        begin
            fb = round_shift(d * longint'(fb_cfg), Q_FRAC);
            slot = clamp_level(longint'(line_mem[ch][wr_ptr]) + fb);
            line_mem[ch][wr_ptr] = slot[SAMPLE_BITS-1:0];
        end
        return d;
    endfunction

    function automatic sfd_out_t predict_echo(input sfd_in_t beat);
        longint xl;
        longint xr;
        longint dl;
        longint dr;
        longint mid;
        longint side;
        longint wl;
        longint wr;
        longint m;
        longint ol;
        longint orr;
        logic [ADDR_W-1:0] rd;
        sfd_out_t res;
        xl = beat.left_in;
        xr = beat.right_in;
        rd = wr_ptr - ADDR_W'(dly_cfg);
        dl = lane_tap(0, xl, rd);
        dr = lane_tap(1, xr, rd);
        mid = dl + dr;
        side = dl - dr;
        wl = clamp_level(round_shift(mid * UNITY + side * longint'(width_cfg), Q_FRAC + 1));
        wr = clamp_level(round_shift(mid * UNITY - side * longint'(width_cfg), Q_FRAC + 1));
        m = (longint'(mix_cfg) > UNITY) ? UNITY : longint'(mix_cfg);
        ol = clamp_level(round_shift(xl * (UNITY - m) + wl * m, Q_FRAC));
        orr = clamp_level(round_shift(xr * (UNITY - m) + wr * m, Q_FRAC));
        res.left_out = ol[SAMPLE_BITS-1:0];
        res.right_out = orr[SAMPLE_BITS-1:0];
        wr_ptr = wr_ptr + ADDR_W'(1);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on output beat %0d: %s", $realtime, out_beats, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_cfg = DELAY_RST;
            fb_cfg = FB_RST;
            mix_cfg = MIX_RST;
            width_cfg = WIDTH_RST;
            wet_cfg = WET_RST;
            wr_ptr = '0;
            foreach (line_mem[c, i])
            begin
                line_mem[c][i] = '0;
            end
            expected_pairs.delete();
            mismatches = 0;
            out_beats = 0;
            awaiting <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
                    REG_DELAY:    dly_cfg = pwdata[DELAY_W-1:0];
                    REG_FEEDBACK: fb_cfg = pwdata[FB_W-1:0];
                    REG_MIX:      mix_cfg = pwdata[GAIN_W-1:0];
                    REG_WIDTH:    width_cfg = pwdata[GAIN_W-1:0];
                    REG_WET:      wet_cfg = pwdata[GAIN_W-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_pairs.push_back(predict_echo(in_data));
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_pairs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat L=%0d R=%0d",
                                              got.left_out, got.right_out));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (got.left_out !== want.left_out)
                    begin
                        report_mismatch($sformatf("left_out got %0d want %0d",
                                                  got.left_out, want.left_out));
                    end
                    if (got.right_out !== want.right_out)
                    begin
                        report_mismatch($sformatf("right_out got %0d want %0d",
                                                  got.right_out, want.right_out));
                    end
                end
                out_beats++;
            end
            awaiting <= expected_pairs.size();
        end
    end

endmodule

// ----- tb/tb_stereo_feedback_delay_unit.sv -----
// Testbench top for the stereo feedback delay: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_stereo_feedback_delay_unit;
    import sfd_pkg::*;

    localparam int STALL_LIMIT    = 3000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_BEATS    = 210;
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_ONE = SAMPLE_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] S_NEG = {SAMPLE_BITS{1'b1}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    sfd_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sfd_out_t              out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   mismatches;
    int   awaiting;
    int   idle_cycles = 0;
    logic no_gaps = 1'b0;
    logic squeeze_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stereo_feedback_delay_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    stereo_delay_checker CHK (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_level();
        int r;
        logic [31:0] u;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return S_MAX;
        end
        if (r < 20) begin
            return S_MIN;
        end
        if (r < 32) begin
            u = $urandom_range(0, 511) - 256;
            return u[SAMPLE_BITS-1:0];
        end
        u = $urandom;
        return u[SAMPLE_BITS-1:0];
    endfunction

    function automatic sfd_in_t pair(input logic [SAMPLE_BITS-1:0] l,
                                     input logic [SAMPLE_BITS-1:0] r);
        sfd_in_t p;
        p.left_in = l;
        p.right_in = r;
        return p;
    endfunction

    function automatic sfd_in_t rand_beat();
        logic [SAMPLE_BITS-1:0] l;
        l = rand_level();
        // about one beat in ten carries identical left and right inputs
        return pair(l, ($urandom_range(0, 9) == 0) ? l : rand_level());
    endfunction

    function automatic int field_bits(input reg_idx_t idx);
        case (idx)
            REG_DELAY:    return DELAY_W;
            REG_FEEDBACK: return FB_W;
            default:      return GAIN_W;
        endcase
    endfunction

    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $urandom_range(0, 48);
        end
        if (r < 80) begin
            return $urandom_range(0, 3000);
        end
        return $urandom_range(0, 16383);
    endfunction

    function automatic logic [31:0] pick_feedback();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 0;
        end
        if (r < 30) begin
            return 65535;
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [31:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 0;
        end
        if (r < 20) begin
            return 65536;
        end
        if (r < 30) begin
            return $urandom_range(65537, 131071);
        end
        return $urandom_range(0, 65536);
    endfunction

    task automatic send_pair(input sfd_in_t beat);
        int g;
        g = gap_len();
        if (g > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (!in_ready);
    endtask

    // random junk above the field's width is dropped by the register
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
        logic [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? ($urandom << field_bits(idx)) : '0;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v | junk;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_all(input logic [31:0] dly, input logic [31:0] fb,
                               input logic [31:0] mix, input logic [31:0] wd,
                               input logic [31:0] wet);
        cfg_write(REG_DELAY, dly);
        cfg_write(REG_FEEDBACK, fb);
        cfg_write(REG_MIX, mix);
        cfg_write(REG_WIDTH, wd);
        cfg_write(REG_WET, wet);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_extremes();
        send_pair(pair(S_MAX, S_MAX));
        send_pair(pair(S_MIN, S_MIN));
        send_pair(pair('0, '0));
        send_pair(pair(S_MAX, S_MIN));
        send_pair(pair(S_MIN, S_MAX));
        send_pair(pair(S_NEG, S_ONE));
        send_pair(pair(S_MAX, '0));
        send_pair(pair('0, S_MIN));
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int g;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else begin
                g = gap_len();
                if (g > 0) begin
                    out_ready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings first, then zero delay with feedback at maximum and the other gains
        // past unity, then one-sample delay with feedback off
        send_extremes();
        wait_drained();
        program_all(0, 65535, 131071, 131071, 131071);
        send_extremes();
        wait_drained();
        program_all(1, 0, 65536, 0, 65536);
        send_extremes();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       program_all(pick_delay(), pick_feedback(), 0, pick_gain(), pick_gain());
                6:       program_all(16383, 65535, 131071, 131071, 131071);
                7:       program_all(0, 58982, 65536, 65536, 65536);
                default: program_all(pick_delay(), pick_feedback(), pick_gain(), pick_gain(),
                                     pick_gain());
            endcase
            no_gaps = (ph % 3 == 2);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                send_pair(rand_beat());
                if (k == 30 && (ph == 1 || ph == 5)) begin
                    squeeze_req = 1'b1;
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end
        else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- stereo_feedback_delay_unit.f -----
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_lane.sv
hw/rtl/sfd_merge.sv
hw/rtl/stereo_feedback_delay_unit.sv
hw/rtl/sfd_checker.sv
tb/stereo_delay_checker.sv
tb/tb_stereo_feedback_delay_unit.sv
